// ----- rtl/mlfq_pkg.sv -----
package mlfq_pkg;

    localparam int LEVEL_W = 3;

    localparam logic [2:0] ST_SLEEPING = 3'd0;
    localparam logic [2:0] ST_RUNNABLE = 3'd1;
    localparam logic [2:0] ST_ZOMBIE   = 3'd2;
    localparam logic [2:0] ST_FREE     = 3'd3;
    localparam logic [2:0] ST_EMBRYO   = 3'd4;
    localparam logic [2:0] ST_RUNNING  = 3'd5;

    localparam logic [2:0] FN_ADMIT = 3'd0;
    localparam logic [2:0] FN_SET   = 3'd1;
    localparam logic [2:0] FN_TICK  = 3'd2;
    localparam logic [2:0] FN_PICK  = 3'd3;
    localparam logic [2:0] FN_YIELD = 3'd4;

    localparam logic [1:0] STS_DONE    = 2'd0;
    localparam logic [1:0] STS_NONE    = 2'd1;
    localparam logic [1:0] STS_NO_SLOT = 2'd2;
    localparam logic [1:0] STS_IGNORED = 2'd3;

    localparam logic [15:0] MAX_AGE_RESET = 16'd30;

    typedef struct packed {
        logic [2:0]         state;
        logic [LEVEL_W-1:0] level;
        logic               queued;
        logic [15:0]        wait_ticks;
        logic [15:0]        runs;
    } t_slot_rec;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADM,
        S_SET_WR,
        S_TICK,
        S_SWP,
        S_SWP_END,
        S_PLVL,
        S_PQRD,
        S_PSRD,
        S_PDEC,
        S_YLD_WR,
        S_DONE
    } t_state;

endpackage

// ----- rtl/mlfq_if.sv -----
interface mlfq_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [5:0] slot;
    logic [1:0] new_state;

    modport source (output valid, output func, output slot, output new_state, input ready);
    modport sink (input valid, input func, input slot, input new_state, output ready);
endinterface

interface mlfq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  chosen_slot;
    logic [2:0]  chosen_level;
    logic [15:0] dispatch_count;

    modport source (output valid, output status, output chosen_slot, output chosen_level,
                    output dispatch_count, input ready);
    modport sink (input valid, input status, input chosen_slot, input chosen_level,
                  input dispatch_count, output ready);
endinterface

// ----- rtl/mlfq_ram.sv -----
module mlfq_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mlfq_scheduler_with_aging.sv -----
// An ignored event goes straight to the result; set state and yield pass through one write
// state; admit and tick walk the slots, one slot a cycle, and admit stops at the first free one.
// Pick: a sweep pass when one is pending, then a scan of each level and its queue entries, and a
// closing sweep when nothing is found. One event is in work at a time; its result is held in
// the output register until taken. Reset is synchronous, active low; a clearing pass then
// writes every slot free, and no transaction is accepted until it ends.
module mlfq_scheduler_with_aging
    import mlfq_pkg::*;
#(
    parameter int NUM_SLOTS   = 64,
    parameter int NUM_LEVELS  = 5,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mlfq_in_if.sink      i_req,
    mlfq_out_if.source   o_rsp,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_data
);

    localparam int SW  = $clog2(NUM_SLOTS);
    localparam int IW  = $clog2(NUM_SLOTS + 1);
    localparam int HW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int LW  = $clog2(NUM_LEVELS);
    localparam int QAW = $clog2(NUM_LEVELS * QUEUE_DEPTH);
    localparam int RW  = $bits(t_slot_rec);

    function automatic logic [HW-1:0] f_tail(logic [HW-1:0] h, logic [CW-1:0] c);
        logic [CW:0] sum;
        sum = (CW+1)'(h) + (CW+1)'(c);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return HW'(sum);
    endfunction

    function automatic logic [HW-1:0] f_next(logic [HW-1:0] h);
        return (h == HW'(QUEUE_DEPTH - 1)) ? '0 : h + HW'(1);
    endfunction

    function automatic logic [QAW-1:0] f_qaddr(logic [LW-1:0] lv, logic [HW-1:0] pos);
        return QAW'(int'(lv) * QUEUE_DEPTH + int'(pos));
    endfunction

    t_state          r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_pv, n_pv;
    logic [SW-1:0]   r_pidx, n_pidx;
    logic [LW:0]     r_lv, n_lv;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_n, n_n;
    logic [SW-1:0]   r_qs, n_qs;
    logic [HW-1:0]   r_head [NUM_LEVELS];
    logic [HW-1:0]   n_head [NUM_LEVELS];
    logic [CW-1:0]   r_cnt [NUM_LEVELS];
    logic [CW-1:0]   n_cnt [NUM_LEVELS];
    logic [SW-1:0]   r_run_slot, n_run_slot;
    logic            r_run_valid, n_run_valid;
    logic            r_sweep_pend, n_sweep_pend;
    logic [15:0]     r_max_age;
    logic [SW-1:0]   r_slot, n_slot;
    logic [2:0]      r_ns, n_ns;
    logic [1:0]      r_st, n_st;
    logic [5:0]      r_cs, n_cs;
    logic [2:0]      r_cl, n_cl;
    logic [15:0]     r_dc, n_dc;
    logic            r_o_valid, n_o_valid;
    logic [1:0]      r_o_status;
    logic [5:0]      r_o_slot;
    logic [2:0]      r_o_level;
    logic [15:0]     r_o_count;

    logic            sm_we;
    logic [SW-1:0]   sm_waddr, sm_raddr;
    t_slot_rec       sm_wdata, rec;
    logic [RW-1:0]   sm_rdata;
    logic            qm_we;
    logic [QAW-1:0]  qm_waddr, qm_raddr;
    logic [SW-1:0]   qm_wdata, qm_rdata;

    logic            w_last;
    logic            w_free;
    logic            w_accept;
    logic            w_load;
    logic            w_slot_bad;

    mlfq_ram #(.W(RW), .DEPTH(NUM_SLOTS)) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_waddr (sm_waddr),
        .i_wdata (RW'(sm_wdata)),
        .i_raddr (sm_raddr),
        .o_rdata (sm_rdata)
    );

    mlfq_ram #(.W(SW), .DEPTH(NUM_LEVELS * QUEUE_DEPTH)) u_queue_mem (
        .i_clk   (i_clk),
        .i_we    (qm_we),
        .i_waddr (qm_waddr),
        .i_wdata (qm_wdata),
        .i_raddr (qm_raddr),
        .o_rdata (qm_rdata)
    );

    assign rec        = t_slot_rec'(sm_rdata);
    assign w_last     = r_pv && (r_pidx == SW'(NUM_SLOTS - 1));
    assign w_free     = r_pv && (rec.state == ST_FREE);
    assign w_accept   = i_req.valid && (r_state == S_IDLE);
    assign w_load     = (r_state == S_DONE) && (!r_o_valid || o_rsp.ready);
    assign w_slot_bad = int'(i_req.slot) >= NUM_SLOTS;

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.chosen_slot    = r_o_slot;
    assign o_rsp.chosen_level   = r_o_level;
    assign o_rsp.dispatch_count = r_o_count;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == IW'(NUM_SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.func)
                        FN_ADMIT: n_state = S_ADM;
                        FN_SET:   n_state = w_slot_bad ? S_DONE : S_SET_WR;
                        FN_TICK:  n_state = S_TICK;
                        FN_PICK: begin
                            if (r_run_valid)       n_state = S_DONE;
                            else if (r_sweep_pend) n_state = S_SWP;
                            else                   n_state = S_PLVL;
                        end
                        FN_YIELD: n_state = r_run_valid ? S_YLD_WR : S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_ADM: begin
                if (w_free || w_last) n_state = S_DONE;
            end
            S_SET_WR:  n_state = S_DONE;
            S_YLD_WR:  n_state = S_DONE;
            S_TICK: begin
                if (w_last) n_state = S_DONE;
            end
            S_SWP: begin
                if (w_last) n_state = S_PLVL;
            end
            S_SWP_END: begin
                if (w_last) n_state = S_DONE;
            end
            S_PLVL: n_state = (r_lv == (LW+1)'(NUM_LEVELS)) ? S_SWP_END : S_PQRD;
            S_PQRD: n_state = (r_i == r_n) ? S_PLVL : S_PSRD;
            S_PSRD: n_state = S_PDEC;
            S_PDEC: begin
                if (rec.state == ST_RUNNABLE) n_state = S_PDEC == r_state ? S_DONE : S_PQRD;
                else                          n_state = S_PQRD;
            end
            S_DONE: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        t_slot_rec      wrec;
        logic           eq_req;
        logic [LW-1:0]  eq_lv;
        logic [LW-1:0]  clv;
        logic           found;
        logic [15:0]    wnew;

        n_idx        = r_idx;
        n_pv         = r_pv;
        n_pidx       = r_pidx;
        n_lv         = r_lv;
        n_i          = r_i;
        n_n          = r_n;
        n_qs         = r_qs;
        n_head       = r_head;
        n_cnt        = r_cnt;
        n_run_slot   = r_run_slot;
        n_run_valid  = r_run_valid;
        n_sweep_pend = r_sweep_pend;
        n_slot       = r_slot;
        n_ns         = r_ns;
        n_st         = r_st;
        n_cs         = r_cs;
        n_cl         = r_cl;
        n_dc         = r_dc;
        n_o_valid    = r_o_valid;

        sm_we    = 1'b0;
        sm_waddr = r_pidx;
        sm_raddr = r_idx[SW-1:0];
        wrec     = rec;
        qm_we    = 1'b0;
        qm_waddr = '0;
        qm_wdata = '0;
        qm_raddr = '0;
        eq_req   = 1'b0;
        eq_lv    = '0;
        clv      = LW'(r_lv[LW-1:0]);
        found    = 1'b0;
        wnew     = '0;

        // Pipelined slot walk: read one slot ahead of the one being processed.
        if (r_state == S_ADM || r_state == S_TICK || r_state == S_SWP ||
            r_state == S_SWP_END) begin
            n_pv   = (r_idx < IW'(NUM_SLOTS));
            n_pidx = r_idx[SW-1:0];
            n_idx  = r_idx + IW'(1);
        end

        unique case (r_state)
            S_CLEAR: begin
                sm_we           = 1'b1;
                sm_waddr        = r_idx[SW-1:0];
                wrec            = '0;
                wrec.state      = ST_FREE;
                n_idx           = r_idx + IW'(1);
            end
            S_IDLE: begin
                n_idx  = '0;
                n_pv   = 1'b0;
                n_lv   = '0;
                n_slot = SW'(i_req.slot);
                n_ns   = 3'(i_req.new_state);
                n_st   = STS_IGNORED;
                n_cs   = '0;
                n_cl   = '0;
                n_dc   = '0;
                if (w_accept) begin
                    case (i_req.func)
                        FN_SET: begin
                            sm_raddr = SW'(i_req.slot);
                            if (!w_slot_bad && r_run_valid && r_run_slot == SW'(i_req.slot)) begin
                                n_run_valid = 1'b0;
                            end
                        end
                        FN_YIELD: sm_raddr = r_run_slot;
                        default: ;
                    endcase
                end
            end
            S_ADM: begin
                if (w_free) begin
                    for (int l = 0; l < NUM_LEVELS; l++) begin
                        if (!found && r_cnt[l] < CW'(QUEUE_DEPTH)) begin
                            found = 1'b1;
                            eq_lv = LW'(l);
                        end
                    end
                    sm_we           = 1'b1;
                    wrec.state      = ST_EMBRYO;
                    wrec.wait_ticks = '0;
                    wrec.runs       = '0;
                    wrec.level      = LEVEL_W'(eq_lv);
                    eq_req          = found;
                    n_st            = STS_DONE;
                    n_cs            = 6'(r_pidx);
                    n_cl            = 3'(eq_lv);
                    n_dc            = '0;
                end else if (w_last) begin
                    n_st = STS_NO_SLOT;
                end
            end
            S_SET_WR: begin
                sm_we      = 1'b1;
                sm_waddr   = r_slot;
                wrec.state = r_ns;
                n_st       = STS_DONE;
                n_cs       = 6'(r_slot);
                n_cl       = 3'(rec.level);
                n_dc       = rec.runs;
            end
            S_YLD_WR: begin
                sm_we       = 1'b1;
                sm_waddr    = r_run_slot;
                n_run_valid = 1'b0;
                wrec.state  = ST_RUNNABLE;
                if (int'(rec.level) + 1 < NUM_LEVELS) begin
                    wrec.level = rec.level + LEVEL_W'(1);
                end
                eq_req = 1'b1;
                eq_lv  = LW'(wrec.level);
                n_st   = STS_DONE;
                n_cs   = 6'(r_run_slot);
                n_cl   = 3'(wrec.level);
                n_dc   = rec.runs;
            end
            S_TICK: begin
                if (r_pv && rec.state != ST_RUNNING && rec.state != ST_FREE) begin
                    sm_we = 1'b1;
                    wnew  = (rec.wait_ticks == 16'hFFFF) ? rec.wait_ticks
                                                         : rec.wait_ticks + 16'd1;
                    wrec.wait_ticks = wnew;
                    if (wnew > r_max_age && rec.level != '0) begin
                        wrec.level      = rec.level - LEVEL_W'(1);
                        wrec.wait_ticks = '0;
                        eq_req          = 1'b1;
                        eq_lv           = LW'(rec.level - LEVEL_W'(1));
                    end
                end
                if (w_last) begin
                    n_st = STS_DONE;
                end
            end
            S_SWP, S_SWP_END: begin
                if (r_pv && rec.state == ST_RUNNABLE) begin
                    sm_we  = 1'b1;
                    eq_req = 1'b1;
                    eq_lv  = '0;
                end
                if (w_last) begin
                    n_sweep_pend = 1'b0;
                    n_lv         = '0;
                    if (r_state == S_SWP_END) n_st = STS_NONE;
                end
            end
            S_PLVL: begin
                n_idx = '0;
                n_pv  = 1'b0;
                n_i   = '0;
                if (r_lv != (LW+1)'(NUM_LEVELS)) n_n = r_cnt[clv];
            end
            S_PQRD: begin
                qm_raddr = f_qaddr(clv, r_head[clv]);
                if (r_i == r_n) n_lv = r_lv + (LW+1)'(1);
            end
            S_PSRD: begin
                n_qs     = qm_rdata;
                sm_raddr = qm_rdata;
            end
            S_PDEC: begin
                n_head[clv] = f_next(r_head[clv]);
                if (rec.state == ST_RUNNABLE) begin
                    n_cnt[clv]      = r_cnt[clv] - CW'(1);
                    sm_we           = 1'b1;
                    sm_waddr        = r_qs;
                    wrec.state      = ST_RUNNING;
                    wrec.queued     = 1'b0;
                    wrec.wait_ticks = '0;
                    wrec.runs       = (rec.runs == 16'hFFFF) ? rec.runs : rec.runs + 16'd1;
                    n_run_slot      = r_qs;
                    n_run_valid     = 1'b1;
                    n_sweep_pend    = 1'b1;
                    n_st            = STS_DONE;
                    n_cs            = 6'(r_qs);
                    n_cl            = 3'(rec.level);
                    n_dc            = wrec.runs;
                end else begin
                    // Not runnable: rotate it to the tail of the same level.
                    qm_we    = 1'b1;
                    qm_waddr = f_qaddr(clv, f_tail(r_head[clv], r_cnt[clv]));
                    qm_wdata = r_qs;
                    n_i      = r_i + CW'(1);
                end
            end
            S_DONE: ;
            default: ;
        endcase

        // Shared enqueue: a slot already in a queue is never queued twice.
        if (eq_req && !rec.queued && r_cnt[eq_lv] < CW'(QUEUE_DEPTH)) begin
            qm_we        = 1'b1;
            qm_waddr     = f_qaddr(eq_lv, f_tail(r_head[eq_lv], r_cnt[eq_lv]));
            qm_wdata     = sm_waddr;
            n_cnt[eq_lv] = r_cnt[eq_lv] + CW'(1);
            wrec.queued  = 1'b1;
        end

        sm_wdata = wrec;

        if (w_load)                         n_o_valid = 1'b1;
        else if (r_o_valid && o_rsp.ready)  n_o_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_pv         <= 1'b0;
            r_run_valid  <= 1'b0;
            r_sweep_pend <= 1'b0;
            r_o_valid    <= 1'b0;
            r_max_age    <= MAX_AGE_RESET;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l] <= '0;
                r_cnt[l]  <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pv         <= n_pv;
            r_run_valid  <= n_run_valid;
            r_sweep_pend <= n_sweep_pend;
            r_o_valid    <= n_o_valid;
            r_head       <= n_head;
            r_cnt        <= n_cnt;
            if (i_cfg_we) begin
                r_max_age <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx     <= n_pidx;
        r_lv       <= n_lv;
        r_i        <= n_i;
        r_n        <= n_n;
        r_qs       <= n_qs;
        r_run_slot <= n_run_slot;
        r_slot     <= n_slot;
        r_ns       <= n_ns;
        r_st       <= n_st;
        r_cs       <= n_cs;
        r_cl       <= n_cl;
        r_dc       <= n_dc;
        if (w_load) begin
            r_o_status <= r_st;
            r_o_slot   <= r_cs;
            r_o_level  <= r_cl;
            r_o_count  <= r_dc;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import mlfq_pkg::*;

    localparam int NSLOT = 64;
    localparam int NLVL = 5;
    localparam int QDEPTH = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [15:0] AGES [5] = '{16'd0, 16'd65535, 16'd3, 16'd30, 16'd12};

    typedef struct packed {
        logic [2:0] func;
        logic [5:0] slot;
        logic [1:0] new_state;
    } t_event;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  chosen_slot;
        logic [2:0]  chosen_level;
        logic [15:0] dispatch_count;
    } t_outcome;

    // One row of the directed table; has_fixed marks an outcome typed in by hand.
    typedef struct packed {
        t_event   ev;
        logic     has_fixed;
        t_outcome fixed;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;

    mlfq_in_if req_if ();
    mlfq_out_if rsp_if ();

    mlfq_scheduler_with_aging dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Scheduler shadow state.
    logic [15:0] age_limit;
    logic [2:0]  sh_state [NSLOT];
    logic [2:0]  sh_level [NSLOT];
    logic        sh_queued [NSLOT];
    logic [15:0] sh_wait [NSLOT];
    logic [15:0] sh_runs [NSLOT];
    logic [5:0]  sh_store [NLVL][QDEPTH];
    int          sh_head [NLVL];
    int          sh_count [NLVL];
    int          run_slot;
    logic        run_valid;
    logic        sweep_due;

    t_outcome expected_q[$];
    int   errors = 0;
    int   cycles = 0;
    logic long_hold = 1'b0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [15:0] sat_inc(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic void shadow_reset();
        age_limit = MAX_AGE_RESET;
        for (int s = 0; s < NSLOT; s++) begin
            sh_state[s] = ST_FREE;
            sh_level[s] = '0;
            sh_queued[s] = 1'b0;
            sh_wait[s] = '0;
            sh_runs[s] = '0;
        end
        for (int l = 0; l < NLVL; l++) begin
            sh_head[l] = 0;
            sh_count[l] = 0;
        end
        run_slot = 0;
        run_valid = 1'b0;
        sweep_due = 1'b0;
    endfunction

    function automatic void enqueue(int lv, int s);
        if (sh_queued[s] || sh_count[lv] >= QDEPTH) return;
        sh_store[lv][(sh_head[lv] + sh_count[lv]) % QDEPTH] = s[5:0];
        sh_count[lv]++;
        sh_queued[s] = 1'b1;
    endfunction

    function automatic int dequeue(int lv);
        int s;
        s = sh_store[lv][sh_head[lv]];
        sh_head[lv] = (sh_head[lv] + 1) % QDEPTH;
        sh_count[lv]--;
        sh_queued[s] = 1'b0;
        return s;
    endfunction

    function automatic void requeue_runnable();
        for (int s = 0; s < NSLOT; s++)
            if (sh_state[s] == ST_RUNNABLE) enqueue(0, s);
        sweep_due = 1'b0;
    endfunction

    function automatic t_outcome schedule_event(t_event ev);
        t_outcome r;
        int s, lv, n;
        r = '0;
        case (ev.func)
            FN_ADMIT: begin
                for (s = 0; s < NSLOT; s++)
                    if (sh_state[s] == ST_FREE) break;
                if (s >= NSLOT) begin
                    r.status = STS_NO_SLOT;
                    return r;
                end
                sh_state[s] = ST_EMBRYO;
                sh_wait[s] = '0;
                sh_runs[s] = '0;
                for (lv = 0; lv < NLVL; lv++)
                    if (sh_count[lv] < QDEPTH) break;
                if (lv >= NLVL) lv = 0;
                else enqueue(lv, s);
                sh_level[s] = lv[2:0];
                r.status = STS_DONE;
                r.chosen_slot = s[5:0];
                r.chosen_level = lv[2:0];
            end
            FN_SET: begin
                s = ev.slot;
                sh_state[s] = {1'b0, ev.new_state};
                if (run_valid && run_slot == s) run_valid = 1'b0;
                r = {STS_DONE, ev.slot, sh_level[s], sh_runs[s]};
            end
            FN_TICK: begin
                for (s = 0; s < NSLOT; s++) begin
                    if (sh_state[s] != ST_RUNNING && sh_state[s] != ST_FREE) begin
                        sh_wait[s] = sat_inc(sh_wait[s]);
                        if (sh_wait[s] > age_limit && sh_level[s] != 0) begin
                            sh_level[s]--;
                            sh_wait[s] = '0;
                            enqueue(sh_level[s], s);
                        end
                    end
                end
                r.status = STS_DONE;
            end
            FN_PICK: begin
                if (run_valid) begin
                    r.status = STS_IGNORED;
                    return r;
                end
                if (sweep_due) requeue_runnable();
                for (lv = 0; lv < NLVL; lv++) begin
                    n = sh_count[lv];
                    for (int i = 0; i < n; i++) begin
                        s = dequeue(lv);
                        if (sh_state[s] == ST_RUNNABLE) begin
                            sh_runs[s] = sat_inc(sh_runs[s]);
                            sh_wait[s] = '0;
                            sh_state[s] = ST_RUNNING;
                            run_slot = s;
                            run_valid = 1'b1;
                            sweep_due = 1'b1;
                            return {STS_DONE, s[5:0], sh_level[s], sh_runs[s]};
                        end
                        enqueue(lv, s);
                    end
                end
                requeue_runnable();
                r.status = STS_NONE;
            end
            FN_YIELD: begin
                if (!run_valid) begin
                    r.status = STS_IGNORED;
                    return r;
                end
                s = run_slot;
                run_valid = 1'b0;
                sh_state[s] = ST_RUNNABLE;
                if (sh_level[s] + 1 < NLVL) sh_level[s]++;
                enqueue(sh_level[s], s);
                r = {STS_DONE, s[5:0], sh_level[s], sh_runs[s]};
            end
            default: r.status = STS_IGNORED;
        endcase
        return r;
    endfunction

    // Sender: every accepted transaction gets its outcome queued here. The idle gap
    // follows the transaction, so valid stays high when the gap is zero.
    task automatic send_event(t_event ev, logic has_fixed, t_outcome fixed);
        t_outcome exp_r;
        int gap;
        req_if.valid <= 1'b1;
        req_if.func <= ev.func;
        req_if.slot <= ev.slot;
        req_if.new_state <= ev.new_state;
        do @(posedge i_clk); while (!req_if.ready);
        exp_r = schedule_event(ev);
        if (has_fixed) exp_r = fixed;
        expected_q.push_back(exp_r);
        gap = $urandom_range(0, 13);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_then_config(logic [15:0] value);
        req_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        age_limit = value;
    endtask

    function automatic t_event rand_event(int mix);
        t_event ev;
        int r;
        r = $urandom_range(0, 99);
        ev.slot = 6'($urandom_range(0, 63));
        ev.new_state = 2'($urandom_range(0, 3));
        if (r < 12) ev.func = FN_ADMIT;
        else if (r < 40) begin
            ev.func = FN_SET;
            // Mostly mark tasks runnable; occasionally touch low slots to hit live ones.
            if ($urandom_range(0, 2) != 0) ev.new_state = ST_RUNNABLE[1:0];
            if ($urandom_range(0, 1) != 0) ev.slot = 6'($urandom_range(0, mix));
        end
        else if (r < 60) ev.func = FN_TICK;
        else if (r < 82) ev.func = FN_PICK;
        else if (r < 97) ev.func = FN_YIELD;
        else ev.func = 3'($urandom_range(5, 7));
        return ev;
    endfunction

    // Directed table.
    t_row dir_tab [] = '{
        '{'{FN_PICK, 6'd0, 2'd0}, 1'b1, '{STS_NONE, 6'd0, 3'd0, 16'd0}},
        '{'{FN_YIELD, 6'd0, 2'd0}, 1'b1, '{STS_IGNORED, 6'd0, 3'd0, 16'd0}},
        '{'{FN_TICK, 6'd0, 2'd0}, 1'b1, '{STS_DONE, 6'd0, 3'd0, 16'd0}},
        '{'{FN_ADMIT, 6'd0, 2'd0}, 1'b1, '{STS_DONE, 6'd0, 3'd0, 16'd0}},
        '{'{FN_ADMIT, 6'd0, 2'd0}, 1'b1, '{STS_DONE, 6'd1, 3'd0, 16'd0}},
        '{'{FN_SET, 6'd63, 2'd3}, 1'b1, '{STS_DONE, 6'd63, 3'd0, 16'd0}},
        '{'{FN_SET, 6'd0, 2'd1}, 1'b0, '0},
        '{'{FN_PICK, 6'd0, 2'd0}, 1'b0, '0},
        '{'{FN_PICK, 6'd0, 2'd0}, 1'b1, '{STS_IGNORED, 6'd0, 3'd0, 16'd0}},
        '{'{FN_TICK, 6'd0, 2'd0}, 1'b0, '0},
        '{'{FN_YIELD, 6'd0, 2'd0}, 1'b0, '0},
        '{'{FN_SET, 6'd1, 2'd2}, 1'b0, '0},
        '{'{FN_PICK, 6'd0, 2'd0}, 1'b0, '0},
        '{'{FN_SET, 6'd0, 2'd0}, 1'b0, '0},
        '{'{FN_PICK, 6'd0, 2'd0}, 1'b0, '0},
        '{'{FN_SET, 6'd0, 2'd1}, 1'b0, '0},
        '{'{FN_PICK, 6'd0, 2'd0}, 1'b0, '0},
        '{'{FN_YIELD, 6'd0, 2'd0}, 1'b0, '0},
        '{'{3'd5, 6'd63, 2'd3}, 1'b1, '{STS_IGNORED, 6'd0, 3'd0, 16'd0}},
        '{'{3'd7, 6'd42, 2'd2}, 1'b1, '{STS_IGNORED, 6'd0, 3'd0, 16'd0}}
    };

    initial begin
        t_event ev;
        req_if.valid = 1'b0;
        req_if.func = '0;
        req_if.slot = '0;
        req_if.new_state = '0;
        shadow_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) send_event(dir_tab[k].ev, dir_tab[k].has_fixed, dir_tab[k].fixed);

        // Walk yield down to the bottom level to show saturation.
        for (int k = 0; k < 7; k++) begin
            send_event('{FN_PICK, 6'd0, 2'd0}, 1'b0, '0);
            send_event('{FN_YIELD, 6'd0, 2'd0}, 1'b0, '0);
        end

        // Phases with different aging limits, the extremes among them.
        for (int p = 0; p < 5; p++) begin
            drain_then_config(AGES[p]);
            if (p == 2) begin
                // Fill every slot so admits run out of room.
                for (int k = 0; k < 70; k++) send_event('{FN_ADMIT, 6'd0, 2'd0}, 1'b0, '0);
                for (int k = 0; k < 64; k++) send_event('{FN_SET, k[5:0], 2'd1}, 1'b0, '0);
                long_hold <= 1'b1;
                for (int k = 0; k < 6; k++) send_event('{FN_TICK, 6'd0, 2'd0}, 1'b0, '0);
                long_hold <= 1'b0;
            end
            for (int k = 0; k < 130; k++) begin
                ev = rand_event(p == 1 ? 63 : 15);
                send_event(ev, 1'b0, '0);
            end
        end

        req_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver with random stalls and long hold-offs while long_hold is set.
    initial begin
        int hold;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                rsp_if.ready <= 1'b0;
                hold = 0;
                while (hold < 400) begin
                    @(posedge i_clk);
                    hold++;
                end
            end
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            rsp_if.ready <= (hold == 0);
            if (hold != 0) begin
                repeat (hold) @(posedge i_clk);
                rsp_if.ready <= 1'b1;
            end
            do @(posedge i_clk); while (!rsp_if.valid);
            rsp_if.ready <= 1'b0;
        end
    end

    // Checker on every accepted result transaction.
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (rsp_if.status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, rsp_if.status);
                    errors++;
                end
                if (rsp_if.chosen_slot !== e.chosen_slot) begin
                    $error("chosen_slot: expected %0d actual %0d", e.chosen_slot,
                           rsp_if.chosen_slot);
                    errors++;
                end
                if (rsp_if.chosen_level !== e.chosen_level) begin
                    $error("chosen_level: expected %0d actual %0d", e.chosen_level,
                           rsp_if.chosen_level);
                    errors++;
                end
                if (rsp_if.dispatch_count !== e.dispatch_count) begin
                    $error("dispatch_count: expected %0d actual %0d", e.dispatch_count,
                           rsp_if.dispatch_count);
                    errors++;
                end
            end
        end
    end

endmodule
